>>> rtl/core/mexp_pkg.sv
package mexp_pkg;

  localparam int WORD_BITS_DEF = 31;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_EXPONENT = 2'd0;
  localparam cfg_idx_t REG_MODULUS  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL_INIT,
    ST_MUL_RUN,
    ST_MUL_END,
    ST_FINISH
  } mexp_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_init;
    logic mul_sel;
    logic mul_step;
    logic acc_write;
    logic e_shift;
    logic res_load;
  } mexp_cmd_t;

  typedef struct packed {
    logic expo_zero;
    logic mod_zero;
    logic ebit;
  } mexp_sts_t;

endpackage

>>> rtl/core/mexp_datapath.sv
module mexp_datapath
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  cfg_idx_t             cfg_index,
  input  logic [WORD_BITS-1:0] cfg_wdata,
  input  logic [WORD_BITS-1:0] in_message,
  input  mexp_cmd_t            cmd,
  output mexp_sts_t            sts,
  output logic [WORD_BITS-1:0] out_result
);

  localparam logic [WORD_BITS-1:0] ONE_W = {{(WORD_BITS-1){1'b0}}, 1'b1};

  logic [WORD_BITS-1:0] exp_key_r, exp_key_nxt;
  logic [WORD_BITS-1:0] mod_key_r, mod_key_nxt;
  logic [WORD_BITS-1:0] msg_sh_r, msg_sh_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] e_sh_r, e_sh_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] mcand_r, mcand_nxt;
  logic [WORD_BITS-1:0] mplier_r, mplier_nxt;
  logic [WORD_BITS-1:0] prod_r, prod_nxt;
  logic [WORD_BITS-1:0] result_r, result_nxt;

  logic [WORD_BITS:0]   mod_ext;
  logic [WORD_BITS:0]   div_t;
  logic [WORD_BITS-1:0] div_r;
  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS-1:0] dbl_red;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS-1:0] sum_red;

  assign mod_ext = {1'b0, mod_key_r};

  always_comb begin
    div_t = {rem_r, msg_sh_r[WORD_BITS-1]};
    div_r = (div_t >= mod_ext) ? div_t[WORD_BITS-1:0] - mod_key_r : div_t[WORD_BITS-1:0];
    dbl = {prod_r, 1'b0};
    dbl_red = (dbl >= mod_ext) ? dbl[WORD_BITS-1:0] - mod_key_r : dbl[WORD_BITS-1:0];
    sum = {1'b0, dbl_red} + (mplier_r[WORD_BITS-1] ? {1'b0, mcand_r} : '0);
    sum_red = (sum >= mod_ext) ? sum[WORD_BITS-1:0] - mod_key_r : sum[WORD_BITS-1:0];
  end

  always_comb begin
    exp_key_nxt = exp_key_r;
    mod_key_nxt = mod_key_r;
    msg_sh_nxt  = msg_sh_r;
    rem_nxt     = rem_r;
    e_sh_nxt    = e_sh_r;
    acc_nxt     = acc_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    prod_nxt    = prod_r;
    result_nxt  = result_r;
    if (cfg_we && (cfg_index == REG_EXPONENT)) begin
      exp_key_nxt = cfg_wdata;
    end
    if (cfg_we && (cfg_index == REG_MODULUS)) begin
      mod_key_nxt = cfg_wdata;
    end
    if (cmd.load) begin
      msg_sh_nxt = in_message;
      rem_nxt    = '0;
      e_sh_nxt   = exp_key_r;
      acc_nxt    = (mod_key_r == ONE_W) ? '0 : ONE_W;
    end
    if (cmd.div_step) begin
      rem_nxt    = div_r;
      msg_sh_nxt = {msg_sh_r[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.mul_init) begin
      mcand_nxt  = acc_r;
      mplier_nxt = cmd.mul_sel ? rem_r : acc_r;
      prod_nxt   = '0;
    end
    if (cmd.mul_step) begin
      prod_nxt   = sum_red;
      mplier_nxt = {mplier_r[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.acc_write) begin
      acc_nxt = prod_r;
    end
    if (cmd.e_shift) begin
      e_sh_nxt = {e_sh_r[WORD_BITS-2:0], 1'b0};
    end
    if (cmd.res_load) begin
      if (exp_key_r == '0) begin
        result_nxt = ONE_W;
      end else if (mod_key_r == '0) begin
        result_nxt = '0;
      end else begin
        result_nxt = acc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_key_r <= ONE_W;
      mod_key_r <= ONE_W;
    end else begin
      exp_key_r <= exp_key_nxt;
      mod_key_r <= mod_key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_sh_r <= msg_sh_nxt;
    rem_r    <= rem_nxt;
    e_sh_r   <= e_sh_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
    result_r <= result_nxt;
  end

  assign sts.expo_zero = (exp_key_r == '0);
  assign sts.mod_zero  = (mod_key_r == '0);
  assign sts.ebit      = e_sh_r[WORD_BITS-1];
  assign out_result    = result_r;

  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (rem_r < mod_key_r))
    else $error("reduced message is not below the modulus");

  a_prod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_step |=> (prod_r < mod_key_r))
    else $error("partial product is not below the modulus");

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_write |=> (acc_r < mod_key_r))
    else $error("accumulator is not below the modulus");

endmodule

>>> rtl/core/mexp_ctrl.sv
module mexp_ctrl
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  mexp_sts_t sts,
  output mexp_cmd_t cmd
);

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_BITS - 1);

  mexp_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ecnt_r, ecnt_nxt;
  logic             sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ecnt_r      <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ecnt_r      <= ecnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ecnt_nxt      = ecnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_stall      = 1'b1;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt  = LAST;
          if (sts.expo_zero || sts.mod_zero) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          ecnt_nxt  = LAST;
          sel_nxt   = 1'b0;
          state_nxt = ST_MUL_INIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MUL_INIT: begin
        cmd.mul_init = 1'b1;
        cmd.mul_sel  = sel_r;
        cnt_nxt      = LAST;
        state_nxt    = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MUL_END;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MUL_END: begin
        cmd.acc_write = 1'b1;
        if (!sel_r && sts.ebit) begin
          sel_nxt   = 1'b1;
          state_nxt = ST_MUL_INIT;
        end else begin
          cmd.e_shift = 1'b1;
          sel_nxt     = 1'b0;
          if (ecnt_r == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            ecnt_nxt  = ecnt_r - 1'b1;
            state_nxt = ST_MUL_INIT;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted transaction did not start work");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= LAST) && (ecnt_r <= LAST))
    else $error("bit counter out of range");

  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && (!out_valid_r || !out_stall)) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished transaction not presented");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && !$past(cmd.res_load)))
    else $error("stalled result overwritten");

endmodule

>>> rtl/core/modular_exponentiation_unit.sv
// Modular exponentiation unit: result = message ** exponent mod modulus.
// The exponent and modulus key registers are written through the cfg_ port
// (index 0 exponent, index 1 modulus); the user must write them only while
// no transaction is in flight, which the block itself does not enforce.
// Input transactions arrive on in_valid/in_stall with in_message; each one
// produces exactly one result transaction on out_valid/out_stall.
// The message is first reduced by a restoring remainder loop over all
// WORD_BITS message bits. Then every exponent bit, most significant first,
// costs one modular squaring plus one modular multiply when the bit is set.
// Each modular multiply runs on the shared shift-add-reduce unit. A zero
// exponent or zero modulus skips both loops and goes to the finish state.
// One transaction is processed at a time; a new message is accepted as soon
// as the previous one has finished, even while its result still waits.
// When the receiver stalls, the result stays on out_result and a finished
// transaction waits until the output register is free.
// Reset sets both key registers to 1 and clears all valid state.
module modular_exponentiation_unit
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  cfg_idx_t             cfg_index,
  input  logic [WORD_BITS-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] in_message,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] out_result
);

  mexp_cmd_t cmd;
  mexp_sts_t sts;

  mexp_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mexp_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_message(in_message),
    .cmd       (cmd),
    .sts       (sts),
    .out_result(out_result)
  );

endmodule

>>> test/mexp_result_checker.sv
module mexp_result_checker
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  cfg_idx_t             cfg_index,
  input  logic [WORD_BITS-1:0] cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [WORD_BITS-1:0] in_message,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [WORD_BITS-1:0] out_result,
  output int                   fail_count,
  output int                   pending
);

  logic [WORD_BITS-1:0] key_exponent;
  logic [WORD_BITS-1:0] key_modulus;
  logic [WORD_BITS-1:0] results_due[$];

  // Right-to-left binary exponentiation; every product fits in 64 bits
  // because both factors stay below the modulus.
  function automatic logic [WORD_BITS-1:0] power_mod(
    input logic [WORD_BITS-1:0] base,
    input logic [WORD_BITS-1:0] expo,
    input logic [WORD_BITS-1:0] modv
  );
    longint unsigned acc;
    longint unsigned sq;
    longint unsigned m;
    if (expo == '0) begin
      return WORD_BITS'(1);
    end
    if (modv == '0) begin
      return '0;
    end
    m = 64'(modv);
    sq = 64'(base) % m;
    acc = 64'd1 % m;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (expo[i]) begin
        acc = (acc * sq) % m;
      end
      sq = (sq * sq) % m;
    end
    return acc[WORD_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    logic [WORD_BITS-1:0] want;
    if (!rst_n) begin
      key_exponent = WORD_BITS'(1);
      key_modulus = WORD_BITS'(1);
      results_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_EXPONENT: key_exponent = cfg_wdata;
          REG_MODULUS:  key_modulus = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result %h arrived with no transaction outstanding", out_result);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (out_result !== want) begin
            $error("result mismatch: expected %h, actual %h", want, out_result);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        results_due.push_back(power_mod(in_message, key_exponent, key_modulus));
      end
    end
    pending = results_due.size();
  end

endmodule

>>> test/tb_modular_exponentiation_unit.sv
module tb_modular_exponentiation_unit;
  import mexp_pkg::*;

  localparam int W = WORD_BITS_DEF;
  localparam int STALL_LIMIT = 12000;
  localparam cfg_idx_t REG_SPARE_A = 2'd2;
  localparam cfg_idx_t REG_SPARE_B = 2'd3;
  localparam logic [W-1:0] WORD_MAX = '1;
  localparam logic [W-1:0] PRIME_PRODUCT = 31'd2146654199;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  cfg_idx_t     cfg_index = REG_EXPONENT;
  logic [W-1:0] cfg_wdata = '0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_message = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_result;
  int           fail_count;
  int           pending;
  int           quiet_cycles = 0;
  logic         calm = 1'b0;
  logic [W-1:0] cur_modulus = W'(1);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modular_exponentiation_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_message(in_message),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(out_result)
  );

  mexp_result_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_message(in_message),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(out_result),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (rst_n && !calm && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic load_keys(input logic [W-1:0] expo, input logic [W-1:0] modv,
                           input bit poke_spare);
    cfg_write(REG_EXPONENT, expo);
    cfg_write(REG_MODULUS, modv);
    if (poke_spare) begin
      cfg_write(REG_SPARE_A, '0);
      cfg_write(REG_SPARE_B, WORD_MAX);
    end
    cfg_we <= 1'b0;
    cur_modulus = modv;
    @(negedge clk);
  endtask

  task automatic push_message(input logic [W-1:0] msg);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_message <= msg;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Lets every outstanding transaction complete so the keys can change.
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return W'(1);
      2: return W'(3);
      3: return W'(65537);
      4: return W'($urandom_range(2, 255));
      5: return WORD_MAX;
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [W-1:0] pick_modulus();
    logic [W-1:0] m;
    case ($urandom_range(0, 9))
      0: m = W'(1);
      1: m = W'($urandom_range(2, 1000));
      2: m = WORD_MAX;
      3: m = PRIME_PRODUCT;
      default: m = W'($urandom);
    endcase
    if (m == '0) begin
      m = W'(1);
    end
    return m;
  endfunction

  function automatic logic [W-1:0] pick_message();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WORD_MAX;
      2: return cur_modulus - 1'b1;
      3: return cur_modulus;
      4: return cur_modulus + 1'b1;
      default: return W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_message('0);
    push_message(WORD_MAX);
    drain();
    load_keys('0, W'(1), 1'b0);
    push_message(W'(12345));
    push_message(WORD_MAX);
    drain();
    load_keys('0, WORD_MAX, 1'b0);
    push_message('0);
    drain();
    load_keys(WORD_MAX, WORD_MAX, 1'b1);
    push_message('0);
    push_message(W'(1));
    push_message(W'(2));
    push_message(WORD_MAX);
    push_message(WORD_MAX - 1'b1);
    drain();
    load_keys(W'(65537), PRIME_PRODUCT, 1'b0);
    push_message(PRIME_PRODUCT - 1'b1);
    push_message(PRIME_PRODUCT);
    push_message(PRIME_PRODUCT + 1'b1);
    push_message(W'(42));
    drain();
    load_keys(W'(3), '0, 1'b0);
    push_message(W'(7));
    push_message('0);
    drain();
    load_keys(W'(1), W'(1000), 1'b1);
    push_message(W'(999));
    push_message(W'(1000));
    push_message(W'(1001));
    push_message(WORD_MAX);
    drain();

    for (int p = 0; p < 9; p++) begin
      calm = (p == 8);
      load_keys(pick_exponent(), pick_modulus(), $urandom_range(0, 3) == 0);
      repeat (30) push_message(pick_message());
      drain();
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
